// ===== hdl/dasf_pkg.sv =====
// package for the delay augmented state feedback controller
// holds sizes, fixed point constants, sequencer types and coefficient address helpers
// no dependencies
`default_nettype none

package dasf_pkg;

   localparam int NUM_SCENARIOS = 4;
   localparam int VECTOR_LEN    = 6;
   localparam int FRAC_BITS     = 24;

   localparam int DATA_W     = 32;
   localparam int GAIN_W     = 31;
   localparam int SCEN_W     = 2;
   localparam int SET_SIZE   = VECTOR_LEN + VECTOR_LEN * VECTOR_LEN + VECTOR_LEN;
   localparam int PHI_BASE   = VECTOR_LEN;
   localparam int GAMMA_BASE = VECTOR_LEN + VECTOR_LEN * VECTOR_LEN;
   localparam int COEF_DEPTH = NUM_SCENARIOS * SET_SIZE;
   localparam int ADDR_W     = $clog2(COEF_DEPTH);
   localparam int IDX_W      = 6;
   localparam int TERM_W     = $clog2(VECTOR_LEN + 1);

   // operand a is 33 bits signed so the unsigned gain fits
   localparam int OPA_W  = DATA_W + 1;
   localparam int PROD_W = OPA_W + DATA_W;
   localparam int ACC_W  = PROD_W + 3;

   // operand selectors into the state vector
   localparam logic [TERM_W-1:0] Z_EST1   = TERM_W'(0);
   localparam logic [TERM_W-1:0] Z_EST2   = TERM_W'(1);
   localparam logic [TERM_W-1:0] Z_OFFSET = TERM_W'(2);
   localparam logic [TERM_W-1:0] Z_EST4   = TERM_W'(3);
   localparam logic [TERM_W-1:0] Z_CURV   = TERM_W'(4);
   localparam logic [TERM_W-1:0] Z_DELAY  = TERM_W'(5);
   localparam logic [TERM_W-1:0] Z_STEER  = TERM_W'(6);

   localparam logic ACT_CONTROL = 1'b0;
   localparam logic ACT_LOAD    = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_DRAIN,
      ST_FINISH,
      ST_DONE
   } state_type;

   typedef enum logic [2:0] {
      PH_CURV,
      PH_STEER,
      PH_ROW0,
      PH_ROW1,
      PH_ROW3
   } phase_type;

   typedef struct packed {
      logic op_valid;
      logic acc_clear;
   } mac_ctrl_type;

   typedef struct packed {
      logic              busy;
      logic              sat;
      logic [DATA_W-1:0] result;
   } mac_stat_type;

   function automatic logic [ADDR_W-1:0] scen_base(input logic [SCEN_W-1:0] scen);
      int s;
      s = int'(scen);
      if (s >= NUM_SCENARIOS) begin
         s = NUM_SCENARIOS - 1;
      end
      return ADDR_W'(s * SET_SIZE);
   endfunction

   function automatic logic [TERM_W-1:0] last_term(input phase_type ph);
      case (ph)
         PH_CURV:  return TERM_W'(0);
         PH_STEER: return TERM_W'(VECTOR_LEN - 1);
         default:  return TERM_W'(VECTOR_LEN);
      endcase
   endfunction

   // offset of a coefficient inside one scenario's set
   function automatic logic [IDX_W-1:0] coef_offset(input phase_type ph,
                                                    input logic [TERM_W-1:0] term);
      int r;
      int t;
      t = int'(term);
      case (ph)
         PH_ROW0: r = 0;
         PH_ROW1: r = 1;
         PH_ROW3: r = 3;
         default: r = 0;
      endcase
      case (ph)
         PH_CURV:  return IDX_W'(0);
         PH_STEER: return IDX_W'(t);
         default: begin
            if (t < VECTOR_LEN) begin
               return IDX_W'(PHI_BASE + r * VECTOR_LEN + t);
            end else begin
               return IDX_W'(GAMMA_BASE + r);
            end
         end
      endcase
   endfunction

endpackage

`default_nettype wire

// ===== hdl/dasf_ram.sv =====
// generic simple dual port ram, one write and one registered read port
// no dependencies
`default_nettype none

module dasf_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 192
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== hdl/dasf_mac.sv =====
// shared multiply accumulate unit with round half up and 32 bit saturation
// depends on dasf_pkg
`default_nettype none

module dasf_mac (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire dasf_pkg::mac_ctrl_type                 ctrl,
   input  wire logic signed [dasf_pkg::OPA_W-1:0]      op_a,
   input  wire logic signed [dasf_pkg::DATA_W-1:0]     op_b,
   output dasf_pkg::mac_stat_type                      stat
);

   localparam int ACC_W  = dasf_pkg::ACC_W;
   localparam int PROD_W = dasf_pkg::PROD_W;
   localparam int FRAC_BITS = dasf_pkg::FRAC_BITS;
   localparam int DATA_W = dasf_pkg::DATA_W;
   localparam int SHR_W  = ACC_W - FRAC_BITS;
   localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) << (FRAC_BITS - 1);

   logic signed [PROD_W-1:0] prod_ff;
   logic                     prod_v_ff;
   logic signed [ACC_W-1:0]  acc_ff;

   logic signed [ACC_W-1:0]  rounded;
   logic signed [SHR_W-1:0]  shifted;
   logic                     all_ones;
   logic                     all_zeros;

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_v_ff <= 1'b0;
         acc_ff    <= '0;
      end else begin
         prod_v_ff <= ctrl.op_valid;
         if (ctrl.acc_clear) begin
            acc_ff <= '0;
         end else if (prod_v_ff) begin
            acc_ff <= acc_ff + {{(ACC_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff};
         end
      end
      if (ctrl.op_valid) begin
         prod_ff <= PROD_W'(op_a * op_b);
      end
   end

   always_comb begin
      rounded   = acc_ff + HALF;
      shifted   = rounded[ACC_W-1:FRAC_BITS];
      all_ones  = &shifted[SHR_W-1:DATA_W-1];
      all_zeros = ~|shifted[SHR_W-1:DATA_W-1];
      stat.busy = prod_v_ff;
      stat.sat  = !(all_ones || all_zeros);
      if (all_ones || all_zeros) begin
         stat.result = shifted[DATA_W-1:0];
      end else if (shifted[SHR_W-1]) begin
         stat.result = {1'b1, {(DATA_W-1){1'b0}}};
      end else begin
         stat.result = {1'b0, {(DATA_W-1){1'b1}}};
      end
   end

endmodule

`default_nettype wire

// ===== hdl/delay_augmented_state_feedback_top.sv =====
// delay augmented state feedback steering controller, top level
// depends on dasf_pkg, dasf_ram, dasf_mac
//
// usage:
//   req channel carries one word per item. tuser says what it is: a load word
//   writes one coefficient into the scenario's set, a control word brings a
//   lateral offset and returns one steering word on the rsp channel.
//   csr_wr_en/csr_wr_data write the curvature gain; write it only while idle.
// timing:
//   a load word does not leave the idle state, so the block is ready again next cycle.
//   a control word runs 28 multiply-accumulates through one shared multiplier
//   (curvature, steering dot product, three estimate rows); after each dot
//   product the sequencer waits in its drain state until the ram read and
//   multiplier pipeline is empty, and takes the rounded sum in its finish state.
//   req_tready stays low until idle again, so no new word is taken before the last is done.
// stall:
//   the result sits in an output register until rsp_tready; a finished item
//   waits in its last state if the previous result has not been taken.
// reset:
//   synchronous reset clears estimates, steering history, gain and control
//   state. the coefficient memory is not cleared; load it before use.
`default_nettype none

module delay_augmented_state_feedback_top (
   input  wire logic        clock,
   input  wire logic        reset,
   // req_tuser: action[0], scenario[2:1], first_step[3]
   input  wire logic [3:0]  req_tuser,
   // req_tdata: lateral_offset[31:0], coef_index[37:32], coef_value[69:38], zero pad
   input  wire logic [71:0] req_tdata,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // rsp_tdata: steering_angle[31:0]
   output logic [31:0]      rsp_tdata,
   // rsp_tuser: overflow[0]
   output logic             rsp_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic        csr_wr_en,
   input  wire logic [30:0] csr_wr_data
);

   localparam int DATA_W = dasf_pkg::DATA_W;
   localparam int ADDR_W = dasf_pkg::ADDR_W;
   localparam int TERM_W = dasf_pkg::TERM_W;
   localparam int OPA_W  = dasf_pkg::OPA_W;

   // input fields
   logic                        f_action;
   logic [dasf_pkg::SCEN_W-1:0] f_scenario;
   logic                        f_first;
   logic [DATA_W-1:0]           f_offset;
   logic [dasf_pkg::IDX_W-1:0]  f_idx;
   logic [DATA_W-1:0]           f_value;

   assign f_action   = req_tuser[0];
   assign f_scenario = req_tuser[2:1];
   assign f_first    = req_tuser[3];
   assign f_offset   = req_tdata[31:0];
   assign f_idx      = req_tdata[37:32];
   assign f_value    = req_tdata[69:38];

   dasf_pkg::state_type state_ff, state_in;
   dasf_pkg::phase_type phase_ff, phase_in;
   logic [TERM_W-1:0]   term_ff, term_in;

   logic [ADDR_W-1:0]        base_ff;
   logic signed [DATA_W-1:0] offset_ff;
   logic                     first_ff;
   logic [dasf_pkg::GAIN_W-1:0] gain_ff;
   logic signed [DATA_W-1:0] est1_ff, est2_ff, est4_ff;
   logic signed [DATA_W-1:0] nxt1_ff, nxt2_ff;
   logic signed [DATA_W-1:0] curv_ff, steer_ff;
   logic signed [DATA_W-1:0] hist0_ff, hist1_ff;
   logic                     ovf_ff;

   logic                     rd_v_ff;
   logic [TERM_W-1:0]        rd_sel_ff;
   logic                     rd_gain_ff;

   logic                     rsp_valid_ff;
   logic [DATA_W-1:0]        rsp_data_ff;
   logic                     rsp_ovf_ff;

   // control outputs of the sequencer
   logic accept_ctrl;
   logic accept_load;
   logic issue;
   logic finish;
   logic load_out;

   logic [ADDR_W-1:0]        wr_addr;
   logic                     wr_en;
   logic [ADDR_W-1:0]        rd_addr;
   logic [DATA_W-1:0]        rd_data;
   logic [TERM_W-1:0]        issue_sel;

   dasf_pkg::mac_ctrl_type   mac_ctrl;
   dasf_pkg::mac_stat_type   mac_stat;
   logic signed [OPA_W-1:0]  op_a;
   logic signed [DATA_W-1:0] op_b;

   // next state
   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      term_in  = term_ff;
      case (state_ff)
         dasf_pkg::ST_IDLE: begin
            if (req_tvalid && f_action == dasf_pkg::ACT_CONTROL) begin
               state_in = dasf_pkg::ST_ISSUE;
               phase_in = dasf_pkg::PH_CURV;
               term_in  = '0;
            end
         end
         dasf_pkg::ST_ISSUE: begin
            if (term_ff == dasf_pkg::last_term(phase_ff)) begin
               state_in = dasf_pkg::ST_DRAIN;
            end else begin
               term_in = term_ff + TERM_W'(1);
            end
         end
         dasf_pkg::ST_DRAIN: begin
            if (!rd_v_ff && !mac_stat.busy) begin
               state_in = dasf_pkg::ST_FINISH;
            end
         end
         dasf_pkg::ST_FINISH: begin
            term_in = '0;
            case (phase_ff)
               dasf_pkg::PH_CURV: begin
                  phase_in = dasf_pkg::PH_STEER;
                  state_in = dasf_pkg::ST_ISSUE;
               end
               dasf_pkg::PH_STEER: begin
                  phase_in = dasf_pkg::PH_ROW0;
                  state_in = dasf_pkg::ST_ISSUE;
               end
               dasf_pkg::PH_ROW0: begin
                  phase_in = dasf_pkg::PH_ROW1;
                  state_in = dasf_pkg::ST_ISSUE;
               end
               dasf_pkg::PH_ROW1: begin
                  phase_in = dasf_pkg::PH_ROW3;
                  state_in = dasf_pkg::ST_ISSUE;
               end
               default: begin
                  state_in = dasf_pkg::ST_DONE;
               end
            endcase
         end
         dasf_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               state_in = dasf_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = dasf_pkg::ST_IDLE;
         end
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_tready  = (state_ff == dasf_pkg::ST_IDLE);
      accept_ctrl = req_tvalid && req_tready && f_action == dasf_pkg::ACT_CONTROL;
      accept_load = req_tvalid && req_tready && f_action == dasf_pkg::ACT_LOAD;
      issue       = (state_ff == dasf_pkg::ST_ISSUE);
      finish      = (state_ff == dasf_pkg::ST_FINISH);
      load_out    = (state_ff == dasf_pkg::ST_DONE) && (!rsp_valid_ff || rsp_tready);
      issue_sel   = (phase_ff == dasf_pkg::PH_CURV) ? dasf_pkg::Z_OFFSET : term_ff;
      mac_ctrl.op_valid  = rd_v_ff;
      mac_ctrl.acc_clear = finish;
   end

   // coefficient memory addressing
   assign wr_en   = accept_load && (int'(f_idx) < dasf_pkg::SET_SIZE);
   assign wr_addr = dasf_pkg::scen_base(f_scenario) + ADDR_W'(f_idx);
   assign rd_addr = base_ff + ADDR_W'(dasf_pkg::coef_offset(phase_ff, term_ff));

   dasf_ram #(
      .WIDTH (DATA_W),
      .DEPTH (dasf_pkg::COEF_DEPTH)
   ) u_coef_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (f_value),
      .rd_en   (issue),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // operand select, valid the cycle after issue when ram data is out
   always_comb begin
      if (rd_gain_ff) begin
         op_a = {2'b00, gain_ff};
      end else begin
         op_a = {rd_data[DATA_W-1], rd_data};
      end
      case (rd_sel_ff)
         dasf_pkg::Z_EST1:   op_b = est1_ff;
         dasf_pkg::Z_EST2:   op_b = est2_ff;
         dasf_pkg::Z_OFFSET: op_b = offset_ff;
         dasf_pkg::Z_EST4:   op_b = est4_ff;
         dasf_pkg::Z_CURV:   op_b = curv_ff;
         dasf_pkg::Z_DELAY:  op_b = first_ff ? '0 : hist1_ff;
         dasf_pkg::Z_STEER:  op_b = steer_ff;
         default:            op_b = '0;
      endcase
   end

   dasf_mac u_mac (
      .clock (clock),
      .reset (reset),
      .ctrl  (mac_ctrl),
      .op_a  (op_a),
      .op_b  (op_b),
      .stat  (mac_stat)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dasf_pkg::ST_IDLE;
         phase_ff     <= dasf_pkg::PH_CURV;
         term_ff      <= '0;
         rd_v_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         gain_ff      <= '0;
         est1_ff      <= '0;
         est2_ff      <= '0;
         est4_ff      <= '0;
         hist0_ff     <= '0;
         hist1_ff     <= '0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         term_ff  <= term_in;
         rd_v_ff  <= issue;
         if (csr_wr_en) begin
            gain_ff <= csr_wr_data;
         end
         if (load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         // last row done: new estimates and history take effect together
         if (finish && phase_ff == dasf_pkg::PH_ROW3) begin
            est1_ff  <= nxt1_ff;
            est2_ff  <= nxt2_ff;
            est4_ff  <= mac_stat.result;
            hist1_ff <= first_ff ? '0 : hist0_ff;
            hist0_ff <= steer_ff;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      rd_sel_ff  <= issue_sel;
      rd_gain_ff <= (phase_ff == dasf_pkg::PH_CURV);
      if (accept_ctrl) begin
         base_ff   <= dasf_pkg::scen_base(f_scenario);
         offset_ff <= f_offset;
         first_ff  <= f_first;
         ovf_ff    <= 1'b0;
      end else if (finish) begin
         ovf_ff <= ovf_ff | mac_stat.sat;
      end
      if (finish) begin
         case (phase_ff)
            dasf_pkg::PH_CURV:  curv_ff  <= mac_stat.result;
            dasf_pkg::PH_STEER: steer_ff <= mac_stat.result;
            dasf_pkg::PH_ROW0:  nxt1_ff  <= mac_stat.result;
            dasf_pkg::PH_ROW1:  nxt2_ff  <= mac_stat.result;
            default: ;
         endcase
      end
      if (load_out) begin
         rsp_data_ff <= steer_ff;
         rsp_ovf_ff  <= ovf_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_ovf_ff;

endmodule

`default_nettype wire

// ===== hdl/dasf_checker.sv =====
// port level checks for the delay augmented state feedback top level
// bound to delay_augmented_state_feedback_top, no other dependencies
`default_nettype none

module dasf_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic [3:0]  req_tuser,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic [31:0] rsp_tdata,
   input wire logic        rsp_tuser,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready
);

   logic req_fire;
   assign req_fire = req_tvalid && req_tready;

   // nothing comes out right after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result word valid right after reset");

   // a control word keeps the block busy
   a_ctrl_busy: assert property (@(posedge clock) disable iff (reset)
      (req_fire && !req_tuser[0]) |=> !req_tready)
      else $error("ready high right after a control word");

   // a load word leaves the block ready in the next cycle
   a_load_quick: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_tuser[0]) |=> req_tready)
      else $error("not ready after a load word");

   // when no result is waiting, none shows up in the cycle after a control word
   a_no_early: assert property (@(posedge clock) disable iff (reset)
      (req_fire && !req_tuser[0] && !rsp_tvalid) |=> !rsp_tvalid)
      else $error("result word too early");

   // stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=>
         (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)))
      else $error("stalled result word changed");

endmodule

bind delay_augmented_state_feedback_top dasf_checker u_dasf_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tuser  (req_tuser),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready)
);

`default_nettype wire

// ===== verif/testbench.sv =====
// self-checking testbench for delay_augmented_state_feedback_top
// predicts each steering word from a local copy of estimates, history and coefficient sets
// depends on dasf_pkg and the rtl under hdl
module testbench;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int SETTLE_CYCLES  = 64;
   localparam int PRINT_LIMIT    = 40;

   localparam logic signed [79:0] ROUND_HALF = 80'sd1 <<< (dasf_pkg::FRAC_BITS - 1);
   localparam logic signed [79:0] SAT_MAX    = 80'sd2147483647;
   localparam logic signed [79:0] SAT_MIN    = -80'sd2147483648;

   typedef enum logic [1:0] {
      RX_OPEN,
      RX_COIN,
      RX_SLOW
   } rx_mode_type;

   logic        clock;
   logic        reset;
   logic [3:0]  req_tuser;
   logic [71:0] req_tdata;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic        csr_wr_en;
   logic [30:0] csr_wr_data;

   // local copy of the controller state
   logic [30:0]        curv_gain;
   logic signed [31:0] est_x1;
   logic signed [31:0] est_x2;
   logic signed [31:0] est_x4;
   logic signed [31:0] steer_prev;
   logic signed [31:0] steer_prev2;
   logic signed [31:0] coef_mem [dasf_pkg::COEF_DEPTH];

   logic [31:0] steer_expect_q [$];
   logic        ovf_expect_q [$];
   logic [31:0] want_steer;
   logic        want_ovf;

   int mismatch_count;
   int quiet_cycles;
   int burst_left;
   int hold_request;

   delay_augmented_state_feedback_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_tuser   (req_tuser),
      .req_tdata   (req_tdata),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   function automatic logic signed [79:0] wide_product(input logic signed [32:0] a,
                                                       input logic signed [32:0] b);
      logic signed [79:0] wa;
      logic signed [79:0] wb;
      wa = a;
      wb = b;
      return wa * wb;
   endfunction

   // returns {saturated, value}; ties round toward plus infinity
   function automatic logic [32:0] round_sat(input logic signed [79:0] acc);
      logic signed [79:0] r;
      r = (acc + ROUND_HALF) >>> dasf_pkg::FRAC_BITS;
      if (r > SAT_MAX) begin
         return {1'b1, 32'h7FFF_FFFF};
      end
      if (r < SAT_MIN) begin
         return {1'b1, 32'h8000_0000};
      end
      return {1'b0, r[31:0]};
   endfunction

   function automatic int set_base(input logic [1:0] scen);
      int s;
      s = int'(scen);
      if (s >= dasf_pkg::NUM_SCENARIOS) begin
         s = dasf_pkg::NUM_SCENARIOS - 1;
      end
      return s * dasf_pkg::SET_SIZE;
   endfunction

   // random Q8.24 value within +-2^shift lsbs
   function automatic logic signed [31:0] rand_q(input int shift);
      logic signed [31:0] v;
      v = $urandom;
      return v >>> (31 - shift);
   endfunction

   function automatic logic signed [31:0] rand_offset();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
         return rand_q(26);
      end else if (pick < 9) begin
         return rand_q(31);
      end
      case ($urandom_range(0, 4))
         0:       return 32'sh7FFF_FFFF;
         1:       return 32'sh8000_0000;
         2:       return 32'sh0000_0000;
         3:       return -32'sd1;
         default: return 32'sd1;
      endcase
   endfunction

   // one control period: curvature, steering dot product, estimate rows 0, 1 and 3
   task automatic predict_steering(input logic [1:0] scen, input logic first,
                                   input logic signed [31:0] offset);
      logic signed [31:0] z [dasf_pkg::VECTOR_LEN];
      logic signed [31:0] next_est [dasf_pkg::VECTOR_LEN];
      logic signed [31:0] steer;
      logic signed [79:0] acc;
      logic [32:0]        rs;
      logic               ovf;
      int                 base;
      int                 row;
      int                 j;
      base = set_base(scen);
      ovf  = 1'b0;
      z[0] = est_x1;
      z[1] = est_x2;
      z[2] = offset;
      z[3] = est_x4;
      rs   = round_sat(wide_product(offset, $signed({2'b00, curv_gain})));
      ovf  = ovf | rs[32];
      z[4] = rs[31:0];
      z[5] = first ? 32'sd0 : steer_prev2;
      acc  = '0;
      for (j = 0; j < dasf_pkg::VECTOR_LEN; j++) begin
         acc += wide_product(coef_mem[base + j], z[j]);
      end
      rs    = round_sat(acc);
      ovf   = ovf | rs[32];
      steer = rs[31:0];
      for (row = 0; row < dasf_pkg::VECTOR_LEN; row++) begin
         next_est[row] = 32'sd0;
         // only rows 0, 1 and 3 are kept, so only they can saturate
         if (row == 0 || row == 1 || row == 3) begin
            acc = '0;
            for (j = 0; j < dasf_pkg::VECTOR_LEN; j++) begin
               acc += wide_product(coef_mem[base + dasf_pkg::PHI_BASE
                                            + row * dasf_pkg::VECTOR_LEN + j], z[j]);
            end
            acc += wide_product(coef_mem[base + dasf_pkg::GAMMA_BASE + row], steer);
            rs            = round_sat(acc);
            ovf           = ovf | rs[32];
            next_est[row] = rs[31:0];
         end
      end
      est_x1      = next_est[0];
      est_x2      = next_est[1];
      est_x4      = next_est[3];
      steer_prev2 = first ? 32'sd0 : steer_prev;
      steer_prev  = steer;
      steer_expect_q.push_back(steer);
      ovf_expect_q.push_back(ovf);
   endtask

   // sends one word in bursts with random gaps; returns at a falling edge
   task automatic send_word(input logic action, input logic [1:0] scen, input logic first,
                            input logic signed [31:0] offset, input logic [5:0] idx,
                            input logic signed [31:0] value);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         repeat (gap) @(negedge clock);
      end
      req_tuser  = {first, scen, action};
      req_tdata  = {2'b00, value, idx, offset};
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      if (action == dasf_pkg::ACT_LOAD) begin
         if (int'(idx) < dasf_pkg::SET_SIZE) begin
            coef_mem[set_base(scen) + int'(idx)] = value;
         end
      end else begin
         predict_steering(scen, first, offset);
      end
      burst_left--;
      @(negedge clock);
      req_tvalid = 1'b0;
   endtask

   task automatic send_control(input logic [1:0] scen, input logic first,
                               input logic signed [31:0] offset);
      send_word(dasf_pkg::ACT_CONTROL, scen, first, offset, 6'($urandom), $urandom);
   endtask

   task automatic send_load(input logic [1:0] scen, input logic [5:0] idx,
                            input logic signed [31:0] value);
      send_word(dasf_pkg::ACT_LOAD, scen, 1'($urandom_range(0, 1)), $urandom, idx, value);
   endtask

   task automatic load_coef_set(input logic [1:0] scen, input int shift);
      int idx;
      for (idx = 0; idx < dasf_pkg::SET_SIZE; idx++) begin
         send_load(scen, 6'(idx), rand_q(shift));
      end
   endtask

   // wait for every steering word, then let a trailing load settle
   task automatic drain_results();
      while (steer_expect_q.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic set_curvature_gain(input logic [30:0] gain);
      csr_wr_en   = 1'b1;
      csr_wr_data = gain;
      curv_gain   = gain;
      @(negedge clock);
      csr_wr_en   = 1'b0;
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      if (mismatch_count < PRINT_LIMIT) begin
         $display("mismatch on %s: got %h, expected %h", what, got, want);
      end
      mismatch_count++;
   endtask

   task automatic test_coefficient_load();
      load_coef_set(2'd0, 22);
      load_coef_set(2'd1, 23);
      load_coef_set(2'd2, 20);
      load_coef_set(2'd3, 31);
   endtask

   // gain of one half turns odd offsets into exact halves
   task automatic test_rounding_ties();
      drain_results();
      set_curvature_gain(31'h0080_0000);
      send_control(2'd2, 1'b1, 32'sd1);
      send_control(2'd2, 1'b0, -32'sd1);
      send_control(2'd2, 1'b0, 32'sd3);
      send_control(2'd2, 1'b0, -32'sd3);
   endtask

   task automatic test_field_extremes();
      drain_results();
      set_curvature_gain(31'h7FFF_FFFF);
      send_load(2'd1, 6'd2, 32'sh7FFF_FFFF);
      send_load(2'd1, 6'd4, 32'sh8000_0000);
      send_load(2'd1, 6'(dasf_pkg::GAMMA_BASE), 32'sh7FFF_FFFF);
      send_load(2'd1, 6'(dasf_pkg::SET_SIZE - 1), 32'sh8000_0000);
      send_control(2'd1, 1'b1, 32'sh7FFF_FFFF);
      send_control(2'd1, 1'b0, 32'sh8000_0000);
      send_control(2'd1, 1'b0, 32'sd0);
      send_control(2'd1, 1'b1, -32'sd1);
      send_control(2'd0, 1'b0, 32'sh7FFF_FFFF);
   endtask

   // loads past the end of a set must not land anywhere; control words then mix first and later steps
   task automatic test_first_step_and_ignored_loads();
      send_load(2'd0, 6'd48, 32'sh7FFF_FFFF);
      send_load(2'd0, 6'd63, 32'sh8000_0000);
      send_control(2'd0, 1'b1, rand_q(24));
      send_control(2'd0, 1'b0, rand_q(24));
      send_control(2'd0, 1'b0, rand_q(24));
      send_control(2'd0, 1'b1, rand_q(24));
      send_control(2'd0, 1'b0, rand_q(24));
   endtask

   // receiver holds off while the sender keeps offering words
   task automatic test_backpressure();
      int n;
      hold_request = 600;
      for (n = 0; n < 16; n++) begin
         send_control(2'($urandom_range(0, 2)), 1'b0, rand_q(25));
      end
   endtask

   task automatic test_random_mix(input int count, input logic [30:0] gain);
      int sent;
      int pick;
      int shift;
      drain_results();
      set_curvature_gain(gain);
      sent = 0;
      while (sent < count) begin
         pick = $urandom_range(0, 99);
         if (pick < 3) begin
            shift = ($urandom_range(0, 5) == 0) ? 31 : $urandom_range(18, 24);
            load_coef_set(2'($urandom), shift);
            sent += dasf_pkg::SET_SIZE;
         end else if (pick < 30) begin
            shift = ($urandom_range(0, 7) == 0) ? 31 : 22;
            send_load(2'($urandom), 6'($urandom), rand_q(shift));
            sent++;
         end else begin
            send_control(2'($urandom), $urandom_range(0, 7) == 0, rand_offset());
            sent++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (steer_expect_q.size() == 0) begin
            report_mismatch("unexpected word", rsp_tdata, 32'h0);
         end else begin
            want_steer = steer_expect_q.pop_front();
            want_ovf   = ovf_expect_q.pop_front();
            if (rsp_tdata !== want_steer) begin
               report_mismatch("steering_angle", rsp_tdata, want_steer);
            end
            if (rsp_tuser !== want_ovf) begin
               report_mismatch("overflow", 32'(rsp_tuser), 32'(want_ovf));
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin : rsp_sink
      int          hold_left;
      int          mode_left;
      int          rx_cycle;
      rx_mode_type mode;
      hold_left  = 0;
      mode_left  = 0;
      rx_cycle   = 0;
      mode       = RX_OPEN;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         rx_cycle++;
         if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
         end
         if (mode_left == 0) begin
            mode      = rx_mode_type'($urandom_range(0, 2));
            mode_left = $urandom_range(100, 400);
         end
         mode_left--;
         if (hold_left != 0) begin
            rsp_tready = 1'b0;
            hold_left--;
         end else begin
            case (mode)
               RX_OPEN: rsp_tready = 1'b1;
               RX_COIN: rsp_tready = 1'($urandom_range(0, 1));
               default: rsp_tready = (rx_cycle % 8 == 0);
            endcase
         end
      end
   end

   initial begin
      reset          = 1'b1;
      req_tuser      = '0;
      req_tdata      = '0;
      req_tvalid     = 1'b0;
      csr_wr_en      = 1'b0;
      csr_wr_data    = '0;
      curv_gain      = '0;
      est_x1         = '0;
      est_x2         = '0;
      est_x4         = '0;
      steer_prev     = '0;
      steer_prev2    = '0;
      mismatch_count = 0;
      quiet_cycles   = 0;
      burst_left     = 0;
      hold_request   = 0;
      foreach (coef_mem[i]) begin
         coef_mem[i] = '0;
      end
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_coefficient_load();
      test_rounding_ties();
      test_field_extremes();
      test_first_step_and_ignored_loads();
      test_backpressure();
      test_random_mix(350, 31'($urandom));
      test_random_mix(350, 31'h7FFF_FFFF);
      test_random_mix(350, 31'h0);
      test_random_mix(350, 31'($urandom_range(0, 32'h01FF_FFFF)));

      drain_results();
      if (mismatch_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
hdl/dasf_pkg.sv
hdl/dasf_ram.sv
hdl/dasf_mac.sv
hdl/delay_augmented_state_feedback_top.sv
hdl/dasf_checker.sv
verif/testbench.sv
